// ===== rtl/arte_pkg.sv =====
`default_nettype none

package arte_pkg;

  // request kinds
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_type_e;

  // rule word selector, the spare code names no word
  typedef enum logic [1:0] {
    WSEL_HDR   = 2'd0,
    WSEL_LOW   = 2'd1,
    WSEL_HIGH  = 2'd2,
    WSEL_SPARE = 2'd3
  } word_sel_e;

  // rule test kinds
  typedef enum logic [2:0] {
    KIND_DIST_IN  = 3'd0,
    KIND_DIST_OUT = 3'd1,
    KIND_VEL      = 3'd2,
    KIND_ACC      = 3'd3,
    KIND_DECEL    = 3'd4,
    KIND_TTC      = 3'd5
  } rule_kind_e;

  // header word bits 17:0, kind in the low bits
  typedef struct packed {
    logic [2:0] level;
    logic [7:0] channels;
    logic [3:0] receiver;
    rule_kind_e kind;
  } rule_hdr_t;

  localparam int unsigned HdrW      = $bits(rule_hdr_t);
  localparam int unsigned EnableBit = 18;

  // channels beyond this never match
  localparam int unsigned ChannelCount = 8;

  // undefined (NaN) flag positions
  localparam int unsigned NanDist  = 0;
  localparam int unsigned NanVel   = 1;
  localparam int unsigned NanAcc   = 2;
  localparam int unsigned NanDecel = 3;
  localparam int unsigned NanTtc   = 4;

  // object quantities under test
  typedef struct packed {
    logic signed [31:0] distance;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic signed [31:0] decel_to_stop;
    logic signed [31:0] time_to_collision;
    logic [4:0]         undefined_flags;
  } obj_t;

endpackage

`default_nettype wire

// ===== rtl/arte_rule_store.sv =====
`default_nettype none

module arte_rule_store
  import arte_pkg::*;
#(
  parameter int unsigned RuleCount = 16,
  parameter int unsigned IdxW      = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire word_sel_e       wr_sel_i,
  input  wire logic [31:0]     wr_word_i,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_idx_i,
  output rule_hdr_t            rd_hdr_o,
  output logic                 rd_enabled_o,
  output logic [31:0]          rd_low_o,
  output logic [31:0]          rd_high_o
);

  rule_hdr_t   hdr_mem  [RuleCount];
  logic [31:0] low_mem  [RuleCount];
  logic [31:0] high_mem [RuleCount];
  logic [RuleCount-1:0] enabled_q;

  // header, low and high bound memories
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      unique case (wr_sel_i)
        WSEL_HDR:  hdr_mem[wr_idx_i]  <= rule_hdr_t'(wr_word_i[HdrW-1:0]);
        WSEL_LOW:  low_mem[wr_idx_i]  <= wr_word_i;
        WSEL_HIGH: high_mem[wr_idx_i] <= wr_word_i;
        default: ;
      endcase
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_hdr_o  <= hdr_mem[rd_idx_i];
      rd_low_o  <= low_mem[rd_idx_i];
      rd_high_o <= high_mem[rd_idx_i];
    end
  end

  // enable bits, all rules off after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= '0;
      rd_enabled_o <= 1'b0;
    end else begin
      if (wr_en_i && (wr_sel_i == WSEL_HDR)) begin
        enabled_q[wr_idx_i] <= wr_word_i[EnableBit];
      end
      if (rd_en_i) begin
        rd_enabled_o <= enabled_q[rd_idx_i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arte_band_unit.sv =====
`default_nettype none

module arte_band_unit
  import arte_pkg::*;
(
  input  wire rule_kind_e  kind_i,
  input  wire logic [31:0] low_i,
  input  wire logic [31:0] high_i,
  input  wire obj_t        obj_i,
  output logic             fire_o
);

  logic signed [31:0] value;
  logic               nan;
  logic               outside;
  logic               known;
  logic               in_band;

  // pick the quantity the rule tests
  always_comb begin
    value   = obj_i.distance;
    nan     = obj_i.undefined_flags[NanDist];
    outside = 1'b0;
    known   = 1'b1;
    case (kind_i)
      KIND_DIST_IN: ;
      KIND_DIST_OUT: outside = 1'b1;
      KIND_VEL: begin
        value = obj_i.velocity;
        nan   = obj_i.undefined_flags[NanVel];
      end
      KIND_ACC: begin
        value = obj_i.acceleration;
        nan   = obj_i.undefined_flags[NanAcc];
      end
      KIND_DECEL: begin
        value = obj_i.decel_to_stop;
        nan   = obj_i.undefined_flags[NanDecel];
      end
      KIND_TTC: begin
        value = obj_i.time_to_collision;
        nan   = obj_i.undefined_flags[NanTtc];
      end
      default: known = 1'b0;
    endcase
  end

  // inclusive signed band test, nan is never inside
  assign in_band = !nan && (value >= $signed(low_i)) && (value <= $signed(high_i));
  assign fire_o  = known && (outside ? !in_band : in_band);

endmodule

`default_nettype wire

// ===== rtl/alert_rule_threat_evaluator_core.sv =====
// load request: the rule word is written on the edge that accepts it
// evaluate request: one rule read per cycle, set by the single rule memory read port;
//   the result is registered from the done state once the output slot is free
// requests: loads are taken every cycle while idle, none is taken during an evaluate
// reset: asynchronous, active low; all rules disabled, output register empty
`default_nettype none

module alert_rule_threat_evaluator_core
  import arte_pkg::*;
#(
  parameter int unsigned RULE_COUNT = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic [3:0]         rule_index_i,
  input  wire logic [1:0]         rule_word_sel_i,
  input  wire logic [31:0]        rule_word_i,
  input  wire logic [3:0]         receiver_id_i,
  input  wire logic [2:0]         channel_id_i,
  input  wire logic signed [31:0] distance_i,
  input  wire logic signed [31:0] velocity_i,
  input  wire logic signed [31:0] acceleration_i,
  input  wire logic signed [31:0] decel_to_stop_i,
  input  wire logic signed [31:0] time_to_collision_i,
  input  wire logic [4:0]         undefined_flags_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              threat_level_o
);

  localparam int unsigned IdxW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RULE_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            chk_vld_q, chk_vld_d;
  logic [2:0]      best_q, best_d;
  logic            out_valid_q, out_valid_d;
  logic [2:0]      level_q, level_d;
  obj_t            obj_q;
  logic [3:0]      rx_q;
  logic [2:0]      ch_q;

  logic            accept;
  logic            is_eval;
  logic [8:0]      wr_idx_ext;
  logic            wr_en;
  logic            push;
  rule_hdr_t       rd_hdr;
  logic            rd_enabled;
  logic [31:0]     rd_low;
  logic [31:0]     rd_high;
  logic            match;
  logic            fire;

  // requests are taken only while idle
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_eval    = (req_type_e'(req_type_i) == REQ_EVAL);

  // load write, ignored past the table or for selector three
  assign wr_idx_ext = {5'b0, rule_index_i};
  assign wr_en = accept && !is_eval
              && (word_sel_e'(rule_word_sel_i) != WSEL_SPARE)
              && (32'(wr_idx_ext) < RULE_COUNT);

  arte_rule_store #(
    .RuleCount(RULE_COUNT),
    .IdxW     (IdxW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_idx_i    (wr_idx_ext[IdxW-1:0]),
    .wr_sel_i    (word_sel_e'(rule_word_sel_i)),
    .wr_word_i   (rule_word_i),
    .rd_en_i     (state_q == ST_SCAN),
    .rd_idx_i    (cnt_q),
    .rd_hdr_o    (rd_hdr),
    .rd_enabled_o(rd_enabled),
    .rd_low_o    (rd_low),
    .rd_high_o   (rd_high)
  );

  arte_band_unit u_band (
    .kind_i(rd_hdr.kind),
    .low_i (rd_low),
    .high_i(rd_high),
    .obj_i (obj_q),
    .fire_o(fire)
  );

  // receiver and channel filter on the rule just read
  assign match = rd_enabled && (rd_hdr.receiver == rx_q)
              && (32'(ch_q) < ChannelCount) && rd_hdr.channels[ch_q];

  // result slot frees when taken
  assign push = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    best_d     = best_q;
    chk_vld_d  = (state_q == ST_SCAN);

    if (chk_vld_q && match && fire && (rd_hdr.level > best_q)) begin
      best_d = rd_hdr.level;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_eval) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          best_d  = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_q == LastIdx) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    level_d     = level_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (push) begin
      out_valid_d = 1'b1;
      level_d     = best_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_vld_q   <= chk_vld_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  // object capture and result payload
  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    if (accept && is_eval) begin
      obj_q.distance          <= distance_i;
      obj_q.velocity          <= velocity_i;
      obj_q.acceleration      <= acceleration_i;
      obj_q.decel_to_stop     <= decel_to_stop_i;
      obj_q.time_to_collision <= time_to_collision_i;
      obj_q.undefined_flags   <= undefined_flags_i;
      rx_q                    <= receiver_id_i;
      ch_q                    <= channel_id_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign threat_level_o = level_q;

endmodule

`default_nettype wire

// ===== rtl/arte_checker.sv =====
`default_nettype none

module arte_checker
  import arte_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       req_type_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] threat_level_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(threat_level_o))
    else $error("result level changed while stalled");

  // an evaluate request occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_e'(req_type_i) == REQ_EVAL) |=> !in_ready_o)
    else $error("ready during evaluation");

  // a load request never blocks the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_e'(req_type_i) == REQ_LOAD) |=> in_ready_o)
    else $error("ready dropped after load");

endmodule

bind alert_rule_threat_evaluator_core arte_checker u_arte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .req_type_i    (req_type_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .threat_level_o(threat_level_o)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import arte_pkg::*;

  localparam int unsigned RuleCount = 16;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct {
    req_type_e          kind;
    logic [3:0]         index;
    logic [1:0]         sel;
    logic [31:0]        word;
    logic [3:0]         receiver;
    logic [2:0]         channel;
    logic signed [31:0] distance;
    logic signed [31:0] velocity;
    logic signed [31:0] accel;
    logic signed [31:0] decel;
    logic signed [31:0] ttc;
    logic [4:0]         nan;
  } request_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               req_type_i = 1'b0;
  logic [3:0]         rule_index_i = '0;
  logic [1:0]         rule_word_sel_i = '0;
  logic [31:0]        rule_word_i = '0;
  logic [3:0]         receiver_id_i = '0;
  logic [2:0]         channel_id_i = '0;
  logic signed [31:0] distance_i = '0;
  logic signed [31:0] velocity_i = '0;
  logic signed [31:0] acceleration_i = '0;
  logic signed [31:0] decel_to_stop_i = '0;
  logic signed [31:0] time_to_collision_i = '0;
  logic [4:0]         undefined_flags_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         threat_level_o;

  // shadow copy of the rule table
  bit                 tbl_enable   [RuleCount];
  logic [2:0]         tbl_kind     [RuleCount];
  logic [3:0]         tbl_receiver [RuleCount];
  logic [7:0]         tbl_channels [RuleCount];
  logic [2:0]         tbl_level    [RuleCount];
  logic signed [31:0] tbl_low      [RuleCount];
  logic signed [31:0] tbl_high     [RuleCount];
  bit                 low_loaded   [RuleCount];
  bit                 high_loaded  [RuleCount];

  logic [2:0] pending_levels [$];

  int fail_count;
  int loads_sent;
  int evals_sent;
  int levels_checked;
  int threats_seen;
  int burst_left;
  bit steady;
  int rx_hold_req;

  alert_rule_threat_evaluator_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .rule_index_i       (rule_index_i),
    .rule_word_sel_i    (rule_word_sel_i),
    .rule_word_i        (rule_word_i),
    .receiver_id_i      (receiver_id_i),
    .channel_id_i       (channel_id_i),
    .distance_i         (distance_i),
    .velocity_i         (velocity_i),
    .acceleration_i     (acceleration_i),
    .decel_to_stop_i    (decel_to_stop_i),
    .time_to_collision_i(time_to_collision_i),
    .undefined_flags_i  (undefined_flags_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .threat_level_o     (threat_level_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bounds are inclusive, an undefined value is never in range
  function automatic bit in_bounds(logic signed [31:0] v, bit undefined, int i);
    return !undefined && v >= tbl_low[i] && v <= tbl_high[i];
  endfunction

  // highest level among the rules that fire for this object
  function automatic logic [2:0] predict_threat_level(request_t r);
    logic [2:0] best;
    bit fire;
    best = '0;
    for (int i = 0; i < RuleCount; i++) begin
      fire = 1'b0;
      if (tbl_enable[i] && tbl_receiver[i] == r.receiver && r.channel < ChannelCount &&
          tbl_channels[i][r.channel]) begin
        case (tbl_kind[i])
          KIND_DIST_IN:  fire = in_bounds(r.distance, r.nan[NanDist], i);
          KIND_DIST_OUT: fire = !in_bounds(r.distance, r.nan[NanDist], i);
          KIND_VEL:      fire = in_bounds(r.velocity, r.nan[NanVel], i);
          KIND_ACC:      fire = in_bounds(r.accel, r.nan[NanAcc], i);
          KIND_DECEL:    fire = in_bounds(r.decel, r.nan[NanDecel], i);
          KIND_TTC:      fire = in_bounds(r.ttc, r.nan[NanTtc], i);
          default:       fire = 1'b0;
        endcase
      end
      if (fire && tbl_level[i] > best) best = tbl_level[i];
    end
    return best;
  endfunction

  // update the shadow table or queue the expected level
  function automatic void apply_request(request_t r);
    rule_hdr_t h;
    if (r.kind == REQ_LOAD) begin
      loads_sent++;
      case (r.sel)
        WSEL_HDR: begin
          h = rule_hdr_t'(r.word[HdrW-1:0]);
          tbl_kind[r.index]     = h.kind;
          tbl_receiver[r.index] = h.receiver;
          tbl_channels[r.index] = h.channels;
          tbl_level[r.index]    = h.level;
          tbl_enable[r.index]   = r.word[EnableBit];
        end
        WSEL_LOW: begin
          tbl_low[r.index]    = r.word;
          low_loaded[r.index] = 1'b1;
        end
        WSEL_HIGH: begin
          tbl_high[r.index]    = r.word;
          high_loaded[r.index] = 1'b1;
        end
        default: ;
      endcase
    end else begin
      evals_sent++;
      pending_levels.insert(pending_levels.size(), predict_threat_level(r));
    end
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.kind     = req_type_e'($urandom_range(0, 1));
    r.index    = 4'($urandom);
    r.sel      = 2'($urandom);
    r.word     = $urandom;
    r.receiver = 4'($urandom);
    r.channel  = 3'($urandom);
    r.distance = $urandom;
    r.velocity = $urandom;
    r.accel    = $urandom;
    r.decel    = $urandom;
    r.ttc      = $urandom;
    r.nan      = 5'($urandom);
    return r;
  endfunction

  function automatic request_t make_load(logic [3:0] idx, logic [1:0] sel, logic [31:0] w);
    request_t r;
    r       = noise_request();
    r.kind  = REQ_LOAD;
    r.index = idx;
    r.sel   = sel;
    r.word  = w;
    return r;
  endfunction

  // directed evaluate, same value for every quantity
  function automatic request_t make_eval(logic [3:0] rx, logic [2:0] ch, logic [31:0] q,
                                         logic [4:0] flags);
    request_t r;
    r          = noise_request();
    r.kind     = REQ_EVAL;
    r.receiver = rx;
    r.channel  = ch;
    r.distance = q;
    r.velocity = q;
    r.accel    = q;
    r.decel    = q;
    r.ttc      = q;
    r.nan      = flags;
    return r;
  endfunction

  // header word with noise in the unused upper bits
  function automatic logic [31:0] rule_header(logic [2:0] kind, logic [3:0] rx,
                                              logic [7:0] mask, logic [2:0] level, bit en);
    rule_hdr_t h;
    logic [31:0] w;
    h.kind     = rule_kind_e'(kind);
    h.receiver = rx;
    h.channels = mask;
    h.level    = level;
    w = $urandom;
    w[HdrW-1:0] = h;
    w[EnableBit] = en;
    return w;
  endfunction

  // value on, just off or inside the band of a rule, at either extreme, or random
  function automatic logic [31:0] near_band(logic [31:0] lo, logic [31:0] hi);
    longint slo;
    longint shi;
    longint unsigned span;
    longint unsigned pick;
    slo = longint'($signed(lo));
    shi = longint'($signed(hi));
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return lo - 32'd1;
      3: return hi + 32'd1;
      4: return 32'h8000_0000;
      5: return 32'h7fff_ffff;
      6: return $urandom;
      default: begin
        if (slo > shi) return $urandom;
        span = longint'(shi - slo + 1);
        pick = {$urandom, $urandom};
        return lo + 32'(pick % span);
      end
    endcase
  endfunction

  function automatic void pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] a;
    logic [31:0] b;
    int c;
    int w;
    case ($urandom_range(0, 5))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      1: begin
        // low above high
        a = $urandom;
        b = $urandom;
        lo = ($signed(a) > $signed(b)) ? a : b;
        hi = ($signed(a) > $signed(b)) ? b : a;
      end
      2: begin
        lo = $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
        hi = lo;
      end
      default: begin
        c = $urandom_range(0, 200 << 16) - (100 << 16);
        w = $urandom_range(0, 20 << 16);
        lo = c - w;
        hi = c + w;
      end
    endcase
  endfunction

  // mostly aimed at an enabled rule so that tests actually fire
  function automatic request_t random_eval();
    request_t r;
    int j;
    int c;
    r = noise_request();
    r.kind = REQ_EVAL;
    j = $urandom_range(0, RuleCount - 1);
    if (tbl_enable[j] && $urandom_range(0, 4) != 0) begin
      r.receiver = tbl_receiver[j];
      if (tbl_channels[j] != 0 && $urandom_range(0, 3) != 0) begin
        c = $urandom_range(0, 7);
        while (!tbl_channels[j][c]) c = (c + 1) % 8;
        r.channel = c[2:0];
      end
      r.distance = near_band(tbl_low[j], tbl_high[j]);
      r.velocity = near_band(tbl_low[j], tbl_high[j]);
      r.accel    = near_band(tbl_low[j], tbl_high[j]);
      r.decel    = near_band(tbl_low[j], tbl_high[j]);
      r.ttc      = near_band(tbl_low[j], tbl_high[j]);
    end
    if ($urandom_range(0, 3) != 0) r.nan = '0;
    return r;
  endfunction

  // offer one request, hold it until accepted, then idle per burst pattern
  task automatic send_request(input request_t r);
    req_type_i          <= r.kind;
    rule_index_i        <= r.index;
    rule_word_sel_i     <= r.sel;
    rule_word_i         <= r.word;
    receiver_id_i       <= r.receiver;
    channel_id_i        <= r.channel;
    distance_i          <= r.distance;
    velocity_i          <= r.velocity;
    acceleration_i      <= r.accel;
    decel_to_stop_i     <= r.decel;
    time_to_collision_i <= r.ttc;
    undefined_flags_i   <= r.nan;
    in_valid_i          <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(r);
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 4)) @(posedge clk_i);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_levels.size() != 0);
  endtask

  // receiver stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin : rx_pattern
    int hold_left;
    int mode_left;
    rx_mode_e rx_mode;
    if (rx_hold_req != 0) begin
      hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
        default:   out_ready_i <= (mode_left % 5) < 2;
      endcase
    end
  end

  // compare each result with the oldest expected level
  always @(posedge clk_i) begin : check_levels
    logic [2:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_levels.size() == 0) begin
        $error("threat_level: no result expected, actual %0d", threat_level_o);
        fail_count++;
      end else begin
        want = pending_levels.pop_front();
        levels_checked++;
        if (threat_level_o != 0) threats_seen++;
        if (threat_level_o !== want) begin
          $error("threat_level: expected %0d, actual %0d", want, threat_level_o);
          fail_count++;
        end
      end
    end
  end

  // every rule disabled after reset
  task automatic test_empty_table();
    send_request(make_eval(4'd0, 3'd0, 32'd0, 5'd0));
  endtask

  // full-range bounds on entry 0, header rewritten for each kind
  task automatic test_rule_kinds();
    logic [31:0] q;
    logic [4:0] own;
    send_request(make_load(4'd0, WSEL_LOW, 32'h8000_0000));
    send_request(make_load(4'd0, WSEL_HIGH, 32'h7fff_ffff));
    for (int k = 0; k < 8; k++) begin
      own = '0;
      case (rule_kind_e'(k))
        KIND_DIST_IN, KIND_DIST_OUT: own[NanDist] = 1'b1;
        KIND_VEL:                    own[NanVel] = 1'b1;
        KIND_ACC:                    own[NanAcc] = 1'b1;
        KIND_DECEL:                  own[NanDecel] = 1'b1;
        KIND_TTC:                    own[NanTtc] = 1'b1;
        default: ;
      endcase
      q = k[0] ? 32'h7fff_ffff : 32'h8000_0000;
      send_request(make_load(4'd0, WSEL_HDR,
                             rule_header(k[2:0], 4'd15, 8'h80, 3'(7 - k), 1'b1)));
      // other quantities undefined must not matter
      send_request(make_eval(4'd15, 3'd7, q, (own == 0) ? 5'd0 : ~own));
    end
  endtask

  // undefined distance, low above high, spare selector, level zero
  task automatic test_special_cases();
    logic [4:0] dist_nan;
    dist_nan = '0;
    dist_nan[NanDist] = 1'b1;
    send_request(make_load(4'd0, WSEL_HDR, rule_header(KIND_DIST_OUT, 4'd15, 8'h80, 3'd7, 1'b1)));
    send_request(make_eval(4'd15, 3'd7, 32'd0, dist_nan));
    send_request(make_load(4'd0, WSEL_LOW, 32'h7fff_ffff));
    send_request(make_load(4'd0, WSEL_HIGH, 32'h8000_0000));
    // if this were taken as a high bound the next test would not fire
    send_request(make_load(4'd0, WSEL_SPARE, 32'h7fff_ffff));
    send_request(make_eval(4'd15, 3'd7, 32'h7fff_ffff, 5'd0));
    send_request(make_load(4'd0, WSEL_HDR, rule_header(KIND_DIST_OUT, 4'd15, 8'h80, 3'd0, 1'b1)));
    send_request(make_eval(4'd15, 3'd7, 32'h7fff_ffff, 5'd0));
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    rx_hold_req = 300;
    steady = 1'b1;
    repeat (12) send_request(random_eval());
    steady = 1'b0;
    wait_for_results();
  endtask

  // rule reloads, stray loads and evaluates
  task automatic test_random_traffic(input int n_items);
    int start;
    int roll;
    logic [3:0] idx;
    logic [1:0] sel;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] w;
    logic [3:0] rx;
    logic [7:0] mask;
    start = loads_sent + evals_sent;
    steady = ($urandom_range(0, 3) == 0);
    while (loads_sent + evals_sent - start < n_items) begin
      roll = $urandom_range(0, 99);
      idx = 4'($urandom_range(0, RuleCount - 1));
      if (roll < 22) begin
        pick_bounds(lo, hi);
        rx = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0:       mask = 8'hff;
          1:       mask = 8'h01 << $urandom_range(0, 7);
          default: mask = 8'($urandom);
        endcase
        w = rule_header(3'($urandom_range(0, 7)), rx, mask, 3'($urandom_range(0, 7)),
                        $urandom_range(0, 7) != 0);
        if (low_loaded[idx] && high_loaded[idx] && $urandom_range(0, 3) == 0) begin
          send_request(make_load(idx, WSEL_HDR, w));
          send_request(make_load(idx, WSEL_LOW, lo));
          send_request(make_load(idx, WSEL_HIGH, hi));
        end else begin
          send_request(make_load(idx, WSEL_LOW, lo));
          send_request(make_load(idx, WSEL_HIGH, hi));
          send_request(make_load(idx, WSEL_HDR, w));
        end
      end else if (roll < 27) begin
        sel = 2'($urandom_range(0, 3));
        w = $urandom;
        // never enable an entry whose bounds are still unwritten
        if (sel == WSEL_HDR && !(low_loaded[idx] && high_loaded[idx])) w[EnableBit] = 1'b0;
        send_request(make_load(idx, sel, w));
      end else begin
        send_request(random_eval());
      end
    end
    steady = 1'b0;
  endtask

  initial begin : run_tests
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_rule_kinds();
    test_special_cases();
    test_backpressure();
    for (int chunk = 0; chunk < 10; chunk++) begin
      test_random_traffic(107);
      if (chunk == 4) wait_for_results();
    end
    wait_for_results();
    repeat (3 * (RuleCount + 1)) @(posedge clk_i);
    $display("covered %0d rule word loads and %0d evaluations", loads_sent, evals_sent);
    $display("%0d threat levels checked, %0d of them nonzero", levels_checked, threats_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
